/* sv/slcu_pkg.sv */
package slcu_pkg;

  // Directory geometry
  localparam int MAX_SET_BITS = 6;
  localparam int MAX_WAYS     = 8;
  localparam int ADDR_WIDTH   = 64;

  localparam int ADDR_W   = 64;
  localparam int TAG_W    = 62;
  localparam int SET_W    = MAX_SET_BITS;
  localparam int NUM_SETS = 1 << SET_W;
  localparam int RANK_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int NW_W     = $clog2(MAX_WAYS + 1);
  localparam int SB_CW    = $clog2(MAX_SET_BITS + 1);
  localparam int CNT_W    = 32;

  localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(MAX_WAYS - 1);
  localparam logic [CNT_W-1:0]  CNT_MAX  = '1;
  localparam logic [ADDR_W-1:0] ADDR_MASK =
    (ADDR_WIDTH >= ADDR_W) ? '1 : ((ADDR_W'(1) << ADDR_WIDTH) - ADDR_W'(1));

  // Configuration register field widths and indexes
  localparam int SET_BITS_W   = 3;
  localparam int BLOCK_BITS_W = 6;
  localparam int WAYS_W       = 4;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 6;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SET_BITS   = 2'd0,
    REG_BLOCK_BITS = 2'd1,
    REG_WAYS       = 2'd2
  } cfg_reg_t;

  // Result codes
  typedef enum logic [1:0] {
    OUT_HIT   = 2'd0,
    OUT_MISS  = 2'd1,
    OUT_EVICT = 2'd2
  } outcome_t;

  // One directory row holds every way of a set
  typedef struct packed {
    logic [MAX_WAYS-1:0]             valid;
    logic [MAX_WAYS-1:0][RANK_W-1:0] rank;
    logic [MAX_WAYS-1:0][TAG_W-1:0]  tag;
  } row_t;

  localparam int ROW_W = $bits(row_t);

endpackage

/* sv/slcu_if.sv */
// Request channel: one request per transfer.
interface slcu_req_if;
  logic                       valid;
  logic                       ready;
  logic                       action;
  logic [slcu_pkg::ADDR_W-1:0] address;

  modport source (output valid, action, address, input ready);
  modport sink   (input valid, action, address, output ready);
endinterface

// Response channel: one result per access.
interface slcu_rsp_if;
  logic                       valid;
  logic                       ready;
  slcu_pkg::outcome_t         outcome;
  logic                       last;
  logic [slcu_pkg::CNT_W-1:0] hit_total;
  logic [slcu_pkg::CNT_W-1:0] miss_total;
  logic [slcu_pkg::CNT_W-1:0] eviction_total;

  modport source (output valid, outcome, last, hit_total, miss_total, eviction_total,
                  input ready);
  modport sink   (input valid, outcome, last, hit_total, miss_total, eviction_total,
                  output ready);
endinterface

// Configuration write channel.
interface slcu_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [slcu_pkg::CFG_IDX_W-1:0]  index;
  logic [slcu_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* sv/set_assoc_lru_cache_hit_miss_unit.sv */
// Tag directory of a set-associative cache with true LRU replacement. Each request
// carries an address and an action: a load or store is one access, a modify is two
// accesses to the same address, and every access returns one result with the hit,
// miss and eviction totals after it. Each access is a read-modify-write of one set
// row in a directory memory with one read and one write port: the row is read (the
// read is issued in the cycle the request is transferred), then updated and written
// back; the update waits while the previous result has not yet been taken. A new
// request is accepted while a result still waits on the response channel. Valid
// bits per set row are held in flip-flops, so the directory is usable straight
// after reset with no clearing pass. Configuration writes are accepted at any time
// and are meant to be issued while the block is idle; the directory is not cleared
// by them.
module set_assoc_lru_cache_hit_miss_unit (
  input  logic        clk,
  input  logic        rst,
  slcu_cfg_if.sink    cfg,
  slcu_req_if.sink    req,
  slcu_rsp_if.source  rsp
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ACC,
    S_RD
  } state_t;

  state_t                               state;
  logic                                 second;
  logic                                 modify;
  logic [slcu_pkg::TAG_W-1:0]           cur_tag;
  logic [slcu_pkg::SET_W-1:0]           cur_set;
  logic [slcu_pkg::SET_BITS_W-1:0]      set_bits;
  logic [slcu_pkg::BLOCK_BITS_W-1:0]    block_bits;
  logic [slcu_pkg::WAYS_W-1:0]          ways_in_use;
  logic [slcu_pkg::NUM_SETS-1:0]        row_init;
  logic [slcu_pkg::CNT_W-1:0]           hits_seen;
  logic [slcu_pkg::CNT_W-1:0]           misses_seen;
  logic [slcu_pkg::CNT_W-1:0]           evictions_seen;
  logic [slcu_pkg::CNT_W-1:0]           hits_next;
  logic [slcu_pkg::CNT_W-1:0]           misses_next;
  logic [slcu_pkg::CNT_W-1:0]           evictions_next;

  logic [slcu_pkg::SB_CW-1:0]           sb_c;
  logic [slcu_pkg::BLOCK_BITS_W-1:0]    bb_c;
  logic [slcu_pkg::NW_W-1:0]            nways_c;
  logic [slcu_pkg::ADDR_W-1:0]          addr_m;
  logic [slcu_pkg::SET_W-1:0]           set_mask;
  logic [slcu_pkg::SET_W-1:0]           in_set;
  logic [slcu_pkg::TAG_W-1:0]           in_tag;

  logic                                 req_xfer;
  logic                                 slot_free;
  logic                                 do_update;
  logic                                 rd_en;
  logic [slcu_pkg::SET_W-1:0]           rd_addr;
  logic [slcu_pkg::ROW_W-1:0]           rd_data;
  slcu_pkg::row_t                       row_cur;
  slcu_pkg::row_t                       row_new;
  slcu_pkg::outcome_t                   outcome;

  // Configuration registers; writes past the last register are dropped.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      set_bits    <= slcu_pkg::SET_BITS_W'(4);
      block_bits  <= slcu_pkg::BLOCK_BITS_W'(4);
      ways_in_use <= slcu_pkg::WAYS_W'(1);
    end else if (cfg.valid) begin
      unique case (cfg.index)
        slcu_pkg::REG_SET_BITS:   set_bits    <= cfg.data[slcu_pkg::SET_BITS_W-1:0];
        slcu_pkg::REG_BLOCK_BITS: block_bits  <= cfg.data[slcu_pkg::BLOCK_BITS_W-1:0];
        slcu_pkg::REG_WAYS:       ways_in_use <= cfg.data[slcu_pkg::WAYS_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the register values to their usable ranges.
  always_comb begin
    if (set_bits == '0) begin
      sb_c = slcu_pkg::SB_CW'(1);
    end else if (int'(set_bits) > slcu_pkg::MAX_SET_BITS) begin
      sb_c = slcu_pkg::SB_CW'(slcu_pkg::MAX_SET_BITS);
    end else begin
      sb_c = slcu_pkg::SB_CW'(set_bits);
    end
    if (block_bits == '0) begin
      bb_c = slcu_pkg::BLOCK_BITS_W'(1);
    end else if (int'(block_bits) > 32) begin
      bb_c = slcu_pkg::BLOCK_BITS_W'(32);
    end else begin
      bb_c = block_bits;
    end
    if (ways_in_use == '0) begin
      nways_c = slcu_pkg::NW_W'(1);
    end else if (int'(ways_in_use) > slcu_pkg::MAX_WAYS) begin
      nways_c = slcu_pkg::NW_W'(slcu_pkg::MAX_WAYS);
    end else begin
      nways_c = slcu_pkg::NW_W'(ways_in_use);
    end
  end

  // Split the request address into set index and tag.
  always_comb begin
    addr_m   = req.address & slcu_pkg::ADDR_MASK;
    set_mask = ~({slcu_pkg::SET_W{1'b1}} << sb_c);
    in_set   = slcu_pkg::SET_W'(addr_m >> bb_c) & set_mask;
    in_tag   = slcu_pkg::TAG_W'(addr_m >> (7'(sb_c) + 7'(bb_c)));
  end

  assign req.ready = (state == S_IDLE);
  assign req_xfer  = req.valid && req.ready;
  assign slot_free = !rsp.valid || rsp.ready;
  assign do_update = (state == S_ACC) && slot_free;

  // Directory read: at request transfer, or for the second access of a modify.
  assign rd_en   = req_xfer || (state == S_RD);
  assign rd_addr = (state == S_RD) ? cur_set : in_set;

  slcu_dir_ram #(
    .WIDTH (slcu_pkg::ROW_W),
    .DEPTH (slcu_pkg::NUM_SETS)
  ) u_dir (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (do_update),
    .wr_addr (cur_set),
    .wr_data (slcu_pkg::ROW_W'(row_new))
  );

  // A row never written reads as its reset value: no valid lines, all ranks zero.
  always_comb begin
    if (row_init[cur_set]) begin
      row_cur = slcu_pkg::row_t'(rd_data);
    end else begin
      row_cur       = slcu_pkg::row_t'(rd_data);
      row_cur.valid = '0;
      row_cur.rank  = '0;
    end
  end

  slcu_set_update u_upd (
    .row_in  (row_cur),
    .tag     (cur_tag),
    .nways   (nways_c),
    .row_out (row_new),
    .outcome (outcome)
  );

  // Saturating totals after this access.
  always_comb begin
    hits_next      = hits_seen;
    misses_next    = misses_seen;
    evictions_next = evictions_seen;
    if (outcome == slcu_pkg::OUT_HIT) begin
      if (hits_seen != slcu_pkg::CNT_MAX) hits_next = hits_seen + 1'b1;
    end else begin
      if (misses_seen != slcu_pkg::CNT_MAX) misses_next = misses_seen + 1'b1;
      if ((outcome == slcu_pkg::OUT_EVICT) && (evictions_seen != slcu_pkg::CNT_MAX)) begin
        evictions_next = evictions_seen + 1'b1;
      end
    end
  end

  // Sequencer, totals, row valid bits and the response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      second         <= 1'b0;
      row_init       <= '0;
      hits_seen      <= '0;
      misses_seen    <= '0;
      evictions_seen <= '0;
      rsp.valid      <= 1'b0;
    end else begin
      // The response register fills on an update and empties on a transfer.
      if (do_update) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_xfer) begin
            modify  <= req.action;
            cur_tag <= in_tag;
            cur_set <= in_set;
            second  <= 1'b0;
            state   <= S_ACC;
          end
        end
        S_ACC: begin
          if (slot_free) begin
            row_init[cur_set]  <= 1'b1;
            hits_seen          <= hits_next;
            misses_seen        <= misses_next;
            evictions_seen     <= evictions_next;
            rsp.outcome        <= outcome;
            rsp.last           <= !(modify && !second);
            rsp.hit_total      <= hits_next;
            rsp.miss_total     <= misses_next;
            rsp.eviction_total <= evictions_next;
            if (modify && !second) begin
              second <= 1'b1;
              state  <= S_RD;
            end else begin
              state  <= S_IDLE;
            end
          end
        end
        S_RD: begin
          state <= S_ACC;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A transferred request always goes to the update step next.
  a_req_to_acc : assert property (@(posedge clk) disable iff (rst)
    req_xfer |=> (state == S_ACC))
    else $error("request transfer not followed by directory update");

  // Each update adds exactly one hit or one miss unless a total is saturated.
  a_one_count : assert property (@(posedge clk) disable iff (rst)
    (do_update && (hits_seen != slcu_pkg::CNT_MAX) && (misses_seen != slcu_pkg::CNT_MAX))
    |=> ((33'(hits_seen) + 33'(misses_seen)) ==
         (33'($past(hits_seen)) + 33'($past(misses_seen)) + 33'd1)))
    else $error("update did not count exactly one hit or miss");

  // Evictions are a subset of misses.
  a_evict_le_miss : assert property (@(posedge clk) disable iff (rst)
    evictions_seen <= misses_seen)
    else $error("eviction total exceeds miss total");

  // The first result of a modify is only shown while its second access is pending.
  a_first_pending : assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.last) |-> ((state == S_RD) || (state == S_ACC)))
    else $error("first result of a modify without its second access pending");

endmodule

/* sv/slcu_dir_ram.sv */
module slcu_dir_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single write port, registered read port that holds between reads.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* sv/slcu_set_update.sv */
module slcu_set_update (
  input  slcu_pkg::row_t                 row_in,
  input  logic [slcu_pkg::TAG_W-1:0]     tag,
  input  logic [slcu_pkg::NW_W-1:0]      nways,
  output slcu_pkg::row_t                 row_out,
  output slcu_pkg::outcome_t             outcome
);

  logic [slcu_pkg::MAX_WAYS-1:0] in_use;
  logic [slcu_pkg::MAX_WAYS-1:0] hit_vec;
  logic [slcu_pkg::MAX_WAYS-1:0] inv_vec;
  logic                          hit;
  logic                          any_inv;
  logic [slcu_pkg::WAY_W-1:0]    hit_way;
  logic [slcu_pkg::WAY_W-1:0]    inv_way;
  logic [slcu_pkg::WAY_W-1:0]    lru_way;
  logic [slcu_pkg::WAY_W-1:0]    way;
  logic [slcu_pkg::RANK_W-1:0]   old_rank;

  // Tag match and free-line search over the ways in use.
  always_comb begin
    for (int j = 0; j < slcu_pkg::MAX_WAYS; j++) begin
      in_use[j]  = (j < int'(nways));
      hit_vec[j] = in_use[j] && row_in.valid[j] && (row_in.tag[j] == tag);
      inv_vec[j] = in_use[j] && !row_in.valid[j];
    end
    hit     = |hit_vec;
    any_inv = |inv_vec;
  end

  // Lowest matching way and lowest free way; scanning downwards leaves the lowest.
  always_comb begin
    hit_way = '0;
    inv_way = '0;
    for (int j = slcu_pkg::MAX_WAYS - 1; j >= 0; j--) begin
      if (hit_vec[j]) begin
        hit_way = slcu_pkg::WAY_W'(j);
      end
      if (inv_vec[j]) begin
        inv_way = slcu_pkg::WAY_W'(j);
      end
    end
  end

  // Oldest way; a tie keeps the lower way.
  always_comb begin
    lru_way = '0;
    for (int j = 1; j < slcu_pkg::MAX_WAYS; j++) begin
      if (in_use[j] && (row_in.rank[j] > row_in.rank[lru_way])) begin
        lru_way = slcu_pkg::WAY_W'(j);
      end
    end
  end

  always_comb begin
    priority if (hit) begin
      way = hit_way;
    end else if (any_inv) begin
      way = inv_way;
    end else begin
      way = lru_way;
    end
  end

  // Age other valid lines (younger only on a hit); way made newest; fill on miss.
  always_comb begin
    old_rank = row_in.rank[way];
    row_out  = row_in;
    for (int j = 0; j < slcu_pkg::MAX_WAYS; j++) begin
      if (in_use[j] && (slcu_pkg::WAY_W'(j) != way) && row_in.valid[j] &&
          (!hit || (row_in.rank[j] < old_rank)) &&
          (row_in.rank[j] != slcu_pkg::RANK_MAX)) begin
        row_out.rank[j] = row_in.rank[j] + slcu_pkg::RANK_W'(1);
      end
    end
    row_out.rank[way] = '0;
    if (!hit) begin
      row_out.valid[way] = 1'b1;
      row_out.tag[way]   = tag;
    end
  end

  always_comb begin
    priority if (hit) begin
      outcome = slcu_pkg::OUT_HIT;
    end else if (any_inv) begin
      outcome = slcu_pkg::OUT_MISS;
    end else begin
      outcome = slcu_pkg::OUT_EVICT;
    end
  end

endmodule
